@@ rtl/core/eibt_pkg.sv @@
package eibt_pkg;

    localparam int DefaultCapacity = 256;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_ECHO   = 2'd3
    } op_t;

    // one queued request between front and back
    typedef struct packed {
        op_t         opcode;
        logic [31:0] ip_address;
        logic [31:0] now_seconds;
        logic [32:0] when;
        logic        reject;
    } req_t;

endpackage

@@ rtl/core/expiring_ip_block_table.sv @@
// path from request beat to result beat: a greylisted add goes straight to the result;
// remove, query and a first-try add scan then write; echo sweeps, scans and writes;
// an add that finds no free slot or its address already present sweeps and retries
// throughput: one request at a time in the table sequencer, one entry per cycle
// a two-beat queue in front lets requests arrive while the back end works
// reset: synchronous active-low aresetn clears all valid bits and control at once
module expiring_ip_block_table
    import eibt_pkg::*;
#(
    parameter int CAPACITY = DefaultCapacity
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_ip_address,
    input  logic [31:0] s_now_seconds,
    input  logic [30:0] s_hold_interval,
    input  logic        s_greylisted,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [32:0] m_expiry_time
);

    logic q_valid, q_ready;
    req_t q_req;

    // front: accept and classify
    eibt_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_ip_address,
        .s_now_seconds, .s_hold_interval, .s_greylisted,
        .q_valid, .q_ready, .q_req
    );

    // back: table sequencer
    eibt_back #(.CAPACITY(CAPACITY)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_req,
        .m_valid, .m_ready, .m_ok, .m_expiry_time
    );

endmodule

@@ rtl/core/eibt_front.sv @@
module eibt_front
    import eibt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_ip_address,
    input  logic [31:0] s_now_seconds,
    input  logic [30:0] s_hold_interval,
    input  logic        s_greylisted,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_req
);

    // two-entry queue of classified requests
    req_t       buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       req_in;
    logic       push, pop;

    // classify: precompute expiry and greylist reject
    always_comb begin
        req_in.opcode      = op_t'(s_opcode);
        req_in.ip_address  = s_ip_address;
        req_in.now_seconds = s_now_seconds;
        req_in.when        = {1'b0, s_now_seconds} + {2'b00, s_hold_interval};
        req_in.reject      = (op_t'(s_opcode) == OP_ADD) && s_greylisted;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = buf_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= req_in;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/core/eibt_back.sv @@
module eibt_back
    import eibt_pkg::*;
#(
    parameter int CAPACITY = DefaultCapacity
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  req_t        q_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [32:0] m_expiry_time
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_WRITE,
        ST_DONE
    } state_t;

    // table storage; valid bits in flops, payload in memories
    logic        valid_reg [CAPACITY];
    logic [31:0] addr_mem  [CAPACITY];
    logic [32:0] exp_mem   [CAPACITY];

    state_t      state_reg;
    req_t        req_reg;
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] idx;
    logic [IW-1:0] rd_idx_reg;
    logic        rd_en_reg;
    logic [31:0] rd_addr_reg;
    logic [32:0] rd_exp_reg;
    logic        rd_vld_reg;
    logic        found_reg;
    logic [IW-1:0] found_idx_reg;
    logic [32:0] found_exp_reg;
    logic        free_reg;
    logic [IW-1:0] free_idx_reg;
    logic        retried_reg;
    logic        ok_reg;
    logic [32:0] exp_out_reg;
    logic        last;
    logic        hit, expd;

    assign idx     = idx_reg[IW-1:0];
    assign last    = (idx_reg == CW'(CAPACITY - 1));
    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);
    assign m_ok    = ok_reg;
    assign m_expiry_time = exp_out_reg;

    // data from the registered memory read, for the idx of the cycle before
    assign hit  = rd_en_reg && rd_vld_reg && (rd_addr_reg == req_reg.ip_address);
    assign expd = {1'b0, req_reg.now_seconds} > rd_exp_reg;

    // memory ports
    always_ff @(posedge aclk) begin
        rd_addr_reg <= addr_mem[idx];
        rd_exp_reg  <= exp_mem[idx];
        rd_vld_reg  <= valid_reg[idx];
        rd_idx_reg  <= idx;
        if (state_reg == ST_WRITE && free_reg && !found_reg) begin
            addr_mem[free_idx_reg] <= req_reg.ip_address;
            exp_mem[free_idx_reg]  <= req_reg.when;
        end
    end

    // sequencer: scan (search, free slot) and sweep passes, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rd_en_reg <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    rd_en_reg <= 1'b0;
                    if (q_valid) begin
                        req_reg     <= q_req;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        free_reg    <= 1'b0;
                        retried_reg <= 1'b0;
                        ok_reg      <= 1'b0;
                        exp_out_reg <= '0;
                        if (q_req.reject) begin
                            state_reg <= ST_DONE;
                        end else if (q_req.opcode == OP_ECHO) begin
                            state_reg <= ST_SWEEP;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SWEEP: begin
                    // drop the previously read entry when it has expired
                    rd_en_reg <= !last || !rd_en_reg ? 1'b1 : 1'b0;
                    if (rd_en_reg && rd_vld_reg && expd) begin
                        valid_reg[rd_idx_reg] <= 1'b0;
                    end
                    if (rd_en_reg && rd_idx_reg == IW'(CAPACITY - 1)) begin
                        rd_en_reg <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end else if (!last) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SCAN: begin
                    // issue reads while capturing the previous entry
                    rd_en_reg <= !last || !rd_en_reg ? 1'b1 : 1'b0;
                    if (rd_en_reg) begin
                        if (hit && !found_reg) begin
                            found_reg     <= 1'b1;
                            found_idx_reg <= rd_idx_reg;
                            found_exp_reg <= rd_exp_reg;
                        end
                        if (!rd_vld_reg && !free_reg) begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                    end
                    if (rd_en_reg && rd_idx_reg == IW'(CAPACITY - 1)) begin
                        rd_en_reg <= 1'b0;
                        state_reg <= ST_WRITE;
                    end else if (!last) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_WRITE: begin
                    state_reg <= ST_DONE;
                    case (req_reg.opcode)
                        OP_ADD: begin
                            if (free_reg && !found_reg) begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                ok_reg <= 1'b1;
                            end else if (!retried_reg) begin
                                // sweep, then scan once more from scratch
                                retried_reg <= 1'b1;
                                idx_reg     <= '0;
                                found_reg   <= 1'b0;
                                free_reg    <= 1'b0;
                                state_reg   <= ST_SWEEP;
                            end
                        end
                        OP_REMOVE: begin
                            ok_reg <= 1'b1;
                            if (found_reg) begin
                                valid_reg[found_idx_reg] <= 1'b0;
                            end
                        end
                        OP_QUERY: begin
                            if (found_reg) begin
                                if ({1'b0, req_reg.now_seconds} <= found_exp_reg) begin
                                    ok_reg <= 1'b1;
                                end else begin
                                    valid_reg[found_idx_reg] <= 1'b0;
                                end
                            end
                        end
                        default: begin
                            if (found_reg) begin
                                ok_reg      <= 1'b1;
                                exp_out_reg <= found_exp_reg;
                            end
                        end
                    endcase
                end
                ST_DONE: begin
                    rd_en_reg <= 1'b0;
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
